FILE: hw/rtl/ttrc_pkg.sv
// ----------------------------------------------------------------------------
// ttrc_pkg: shared types and constants for the touch to rgb color block
// field widths, hue sector codes, job record passed from front to back
// ----------------------------------------------------------------------------
package ttrc_pkg;

  localparam int X_W         = 9;
  localparam int Y_W         = 8;
  localparam int C_W         = 8;
  localparam int H3_W        = 11;
  localparam int SEC_W       = 3;
  localparam int FR_W        = 8;
  localparam int TERM_W      = 16;
  localparam int NUM_W       = 24;
  localparam int RECIP_SHIFT = 24;
  localparam int CIDX_W      = 2;
  localparam int COMP_N      = 4;

  localparam int SECTOR_SPAN_I  = 160;
  localparam int SEC_FULL_MAX   = (3 * ((1 << X_W) - 1)) / SECTOR_SPAN_I;
  localparam int SEC_FULL_W     = $clog2(SEC_FULL_MAX + 1);

  localparam int QDEPTH  = 2;
  localparam int QPTR_W  = 1;
  localparam int QCNT_W  = 2;

  localparam logic [X_W-1:0]    HUE_WRAP_X  = 9'd320;
  localparam logic [H3_W-1:0]   SECTOR_SPAN = 11'd160;
  localparam logic [TERM_W-1:0] FULL_TERM   = 16'd40800;
  localparam logic [C_W-1:0]    C_MAX       = 8'hFF;

  // hue sectors
  localparam logic [SEC_W-1:0] SEC_RY = 3'd0;
  localparam logic [SEC_W-1:0] SEC_YG = 3'd1;
  localparam logic [SEC_W-1:0] SEC_GC = 3'd2;
  localparam logic [SEC_W-1:0] SEC_CB = 3'd3;
  localparam logic [SEC_W-1:0] SEC_BM = 3'd4;
  localparam logic [SEC_W-1:0] SEC_MR = 3'd5;

  // component slots computed per job
  localparam logic [CIDX_W-1:0] CMP_V = 2'd0;
  localparam logic [CIDX_W-1:0] CMP_P = 2'd1;
  localparam logic [CIDX_W-1:0] CMP_Q = 2'd2;
  localparam logic [CIDX_W-1:0] CMP_T = 2'd3;

  typedef struct packed {
    logic [SEC_W-1:0] sector;
    logic [FR_W-1:0]  frac;
    logic [Y_W-1:0]   y;
  } job_t;

  typedef struct packed {
    logic valid;
    logic ready;
  } qstat_t;

endpackage

FILE: hw/rtl/ttrc_in_if.sv
// ----------------------------------------------------------------------------
// ttrc_in_if: touch sample channel
// valid/ready handshake carrying one touch sample per beat
// ----------------------------------------------------------------------------
interface ttrc_in_if;
  logic                     valid;
  logic                     ready;
  logic                     touch_valid;
  logic [ttrc_pkg::X_W-1:0] touch_x;
  logic [ttrc_pkg::Y_W-1:0] touch_y;

  modport source (output valid, output touch_valid, output touch_x, output touch_y,
                  input ready);
  modport sink   (input valid, input touch_valid, input touch_x, input touch_y,
                  output ready);
endinterface

FILE: hw/rtl/ttrc_out_if.sv
// ----------------------------------------------------------------------------
// ttrc_out_if: rgb result channel
// valid/ready handshake carrying one color triple per beat
// ----------------------------------------------------------------------------
interface ttrc_out_if;
  logic                     valid;
  logic                     ready;
  logic [ttrc_pkg::C_W-1:0] red;
  logic [ttrc_pkg::C_W-1:0] green;
  logic [ttrc_pkg::C_W-1:0] blue;

  modport source (output valid, output red, output green, output blue, input ready);
  modport sink   (input valid, input red, input green, input blue, output ready);
endinterface

FILE: hw/rtl/ttrc_queue.sv
// ----------------------------------------------------------------------------
// ttrc_queue: short job queue between front and back
// two-entry fifo, lets the front accept while the back is busy
// ----------------------------------------------------------------------------
module ttrc_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  ttrc_pkg::job_t    push_job,
  input  logic              pop,
  output ttrc_pkg::job_t    head_job,
  output ttrc_pkg::qstat_t  stat
);

  ttrc_pkg::job_t                  mem [ttrc_pkg::QDEPTH];
  logic [ttrc_pkg::QPTR_W-1:0]     wr_ptr_r, wr_ptr_nxt;
  logic [ttrc_pkg::QPTR_W-1:0]     rd_ptr_r, rd_ptr_nxt;
  logic [ttrc_pkg::QCNT_W-1:0]     cnt_r, cnt_nxt;

  assign stat.valid = (cnt_r != '0);
  assign stat.ready = (cnt_r != ttrc_pkg::QCNT_W'(ttrc_pkg::QDEPTH));
  assign head_job   = mem[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop  ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r + ttrc_pkg::QCNT_W'(push) - ttrc_pkg::QCNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_job;
    end
  end

endmodule

FILE: hw/rtl/ttrc_front.sv
// ----------------------------------------------------------------------------
// ttrc_front: touch sample filter and hue classifier
// drops idle and repeated samples, splits hue into sector and fraction
// ----------------------------------------------------------------------------
module ttrc_front (
  input  logic              clk,
  input  logic              rst_n,
  ttrc_in_if.sink           in_chan,
  input  ttrc_pkg::qstat_t  q_stat,
  output logic              push,
  output ttrc_pkg::job_t    push_job
);

  logic [ttrc_pkg::X_W-1:0]        last_x_r, last_x_nxt;
  logic [ttrc_pkg::Y_W-1:0]        last_y_r, last_y_nxt;
  logic                            beat;
  logic                            moved;
  logic [ttrc_pkg::H3_W-1:0]       h3;
  logic [ttrc_pkg::H3_W-1:0]       rem_full;
  logic [ttrc_pkg::SEC_FULL_W-1:0] sec_full;

  assign in_chan.ready = q_stat.ready;
  assign beat  = in_chan.valid && in_chan.ready;
  assign moved = (in_chan.touch_x != last_x_r) || (in_chan.touch_y != last_y_r);
  assign push  = beat && in_chan.touch_valid && moved;

  // hue*3/... in units of 1/160 sector; full circle wraps to zero
  always_comb begin
    if (in_chan.touch_x == ttrc_pkg::HUE_WRAP_X) begin
      h3 = '0;
    end else begin
      h3 = ttrc_pkg::H3_W'(in_chan.touch_x) + ttrc_pkg::H3_W'({in_chan.touch_x, 1'b0});
    end
    sec_full = '0;
    for (int k = 1; k <= ttrc_pkg::SEC_FULL_MAX; k++) begin
      if (h3 >= ttrc_pkg::H3_W'(k * ttrc_pkg::SECTOR_SPAN_I)) begin
        sec_full = ttrc_pkg::SEC_FULL_W'(k);
      end
    end
    rem_full = h3 - ttrc_pkg::H3_W'(ttrc_pkg::H3_W'(sec_full) * ttrc_pkg::SECTOR_SPAN);
    push_job.frac = rem_full[ttrc_pkg::FR_W-1:0];
    push_job.y    = in_chan.touch_y;
    // past a full circle the last sector applies
    if (sec_full > ttrc_pkg::SEC_FULL_W'(ttrc_pkg::SEC_MR)) begin
      push_job.sector = ttrc_pkg::SEC_MR;
    end else begin
      push_job.sector = sec_full[ttrc_pkg::SEC_W-1:0];
    end
  end

  always_comb begin
    last_x_nxt = push ? in_chan.touch_x : last_x_r;
    last_y_nxt = push ? in_chan.touch_y : last_y_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_x_r <= '0;
      last_y_r <= '0;
    end else begin
      last_x_r <= last_x_nxt;
      last_y_r <= last_y_nxt;
    end
  end

endmodule

FILE: hw/rtl/ttrc_back.sv
// ----------------------------------------------------------------------------
// ttrc_back: hsv to rgb arithmetic
// one pipelined scale-and-divide unit shared by the v, p, q, t components
// ----------------------------------------------------------------------------
module ttrc_back #(
  parameter int TOUCH_HEIGHT = 240
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  ttrc_pkg::qstat_t         q_stat,
  input  ttrc_pkg::job_t           head_job,
  output logic                     pop,
  input  logic [ttrc_pkg::C_W-1:0] sat,
  ttrc_out_if.source               out_chan
);

  localparam int DIV     = ttrc_pkg::SECTOR_SPAN_I * TOUCH_HEIGHT;
  localparam int DIV_W   = $clog2(DIV + 1);
  localparam int RECIP   = (1 << ttrc_pkg::RECIP_SHIFT) / DIV;
  localparam int RECIP_W = $clog2(RECIP + 1);
  localparam int PROD_W  = ttrc_pkg::NUM_W + RECIP_W;
  localparam int Q_W     = (RECIP_W > 9) ? RECIP_W : 9;
  localparam int QD_W    = ttrc_pkg::C_W + DIV_W;

  localparam int NW = ttrc_pkg::NUM_W;
  localparam int TW = ttrc_pkg::TERM_W;
  localparam int CW = ttrc_pkg::C_W;
  localparam int IW = ttrc_pkg::CIDX_W;

  logic                 busy_r, busy_nxt;
  logic                 iss_on_r, iss_on_nxt;
  logic [IW-1:0]        iss_cnt_r, iss_cnt_nxt;
  ttrc_pkg::job_t       job_r;

  logic                 p1_vld_r, p2_vld_r, p3_vld_r, p4_vld_r;
  logic [IW-1:0]        p1_idx_r, p2_idx_r, p3_idx_r, p4_idx_r;
  logic [TW-1:0]        p1_term_r;
  logic [NW-1:0]        p2_num_r, p3_num_r, p4_num_r;
  logic [PROD_W-1:0]    p3_prod_r;
  logic [CW-1:0]        p4_q_r;
  logic                 p4_clip_r;
  logic [QD_W-1:0]      p4_qd_r;

  logic [CW-1:0]        comp_r [ttrc_pkg::COMP_N];
  logic [CW-1:0]        comp_nxt [ttrc_pkg::COMP_N];

  logic                 out_vld_r, out_vld_nxt;
  logic [CW-1:0]        red_r, green_r, blue_r;
  logic [CW-1:0]        red_nxt, green_nxt, blue_nxt;

  logic                 out_beat;
  logic                 done;
  logic [CW-1:0]        frac_sel;
  logic [TW-1:0]        sf;
  logic [TW-1:0]        term;
  logic [Q_W-1:0]       q0;
  logic [NW-1:0]        rem;
  logic [CW:0]          qc;
  logic [CW-1:0]        res;
  logic [CW-1:0]        cv, cp, cq, ct;

  assign out_beat = out_vld_r && out_chan.ready;
  assign pop      = q_stat.valid && !busy_r && (!out_vld_r || out_chan.ready);
  assign done     = p4_vld_r && (p4_idx_r == ttrc_pkg::CMP_T);

  // stage 1 operand: scaled by 160 so all four share one divisor
  always_comb begin
    frac_sel = (iss_cnt_r == ttrc_pkg::CMP_Q) ? job_r.frac :
               CW'(ttrc_pkg::SECTOR_SPAN_I) - job_r.frac;
    sf = TW'(sat) * TW'(frac_sel);
    unique case (iss_cnt_r)
      ttrc_pkg::CMP_V: term = ttrc_pkg::FULL_TERM;
      ttrc_pkg::CMP_P: term = TW'(TW'(ttrc_pkg::C_MAX - sat) * TW'(ttrc_pkg::SECTOR_SPAN_I));
      default:         term = ttrc_pkg::FULL_TERM - sf;
    endcase
  end

  assign q0 = Q_W'(p3_prod_r >> ttrc_pkg::RECIP_SHIFT);

  // one-step correction of the reciprocal estimate, then clip
  always_comb begin
    rem = p4_num_r - NW'(p4_qd_r);
    qc  = {1'b0, p4_q_r} + (CW+1)'(rem >= NW'(DIV));
    res = (p4_clip_r || qc[CW]) ? ttrc_pkg::C_MAX : qc[CW-1:0];
    for (int i = 0; i < ttrc_pkg::COMP_N; i++) begin
      comp_nxt[i] = comp_r[i];
    end
    if (p4_vld_r) begin
      comp_nxt[p4_idx_r] = res;
    end
  end

  always_comb begin
    cv = comp_nxt[ttrc_pkg::CMP_V];
    cp = comp_nxt[ttrc_pkg::CMP_P];
    cq = comp_nxt[ttrc_pkg::CMP_Q];
    ct = comp_nxt[ttrc_pkg::CMP_T];
    red_nxt   = red_r;
    green_nxt = green_r;
    blue_nxt  = blue_r;
    if (done) begin
      unique case (job_r.sector)
        ttrc_pkg::SEC_RY: begin red_nxt = cv; green_nxt = ct; blue_nxt = cp; end
        ttrc_pkg::SEC_YG: begin red_nxt = cq; green_nxt = cv; blue_nxt = cp; end
        ttrc_pkg::SEC_GC: begin red_nxt = cp; green_nxt = cv; blue_nxt = ct; end
        ttrc_pkg::SEC_CB: begin red_nxt = cp; green_nxt = cq; blue_nxt = cv; end
        ttrc_pkg::SEC_BM: begin red_nxt = ct; green_nxt = cp; blue_nxt = cv; end
        default:          begin red_nxt = cv; green_nxt = cp; blue_nxt = cq; end
      endcase
    end
  end

  always_comb begin
    busy_nxt    = busy_r;
    iss_on_nxt  = iss_on_r;
    iss_cnt_nxt = iss_cnt_r;
    out_vld_nxt = out_vld_r;
    if (out_beat) begin
      out_vld_nxt = 1'b0;
    end
    if (done) begin
      busy_nxt    = 1'b0;
      out_vld_nxt = 1'b1;
    end
    if (iss_on_r) begin
      iss_cnt_nxt = iss_cnt_r + 1'b1;
      if (iss_cnt_r == ttrc_pkg::CMP_T) begin
        iss_on_nxt = 1'b0;
      end
    end
    if (pop) begin
      busy_nxt    = 1'b1;
      iss_on_nxt  = 1'b1;
      iss_cnt_nxt = ttrc_pkg::CMP_V;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r    <= 1'b0;
      iss_on_r  <= 1'b0;
      iss_cnt_r <= '0;
      out_vld_r <= 1'b0;
      p1_vld_r  <= 1'b0;
      p2_vld_r  <= 1'b0;
      p3_vld_r  <= 1'b0;
      p4_vld_r  <= 1'b0;
    end else begin
      busy_r    <= busy_nxt;
      iss_on_r  <= iss_on_nxt;
      iss_cnt_r <= iss_cnt_nxt;
      out_vld_r <= out_vld_nxt;
      p1_vld_r  <= iss_on_r;
      p2_vld_r  <= p1_vld_r;
      p3_vld_r  <= p2_vld_r;
      p4_vld_r  <= p3_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      job_r <= head_job;
    end
    p1_idx_r  <= iss_cnt_r;
    p1_term_r <= term;
    p2_idx_r  <= p1_idx_r;
    p2_num_r  <= NW'(job_r.y) * NW'(p1_term_r);
    p3_idx_r  <= p2_idx_r;
    p3_num_r  <= p2_num_r;
    p3_prod_r <= PROD_W'(p2_num_r) * PROD_W'(RECIP);
    p4_idx_r  <= p3_idx_r;
    p4_num_r  <= p3_num_r;
    p4_q_r    <= q0[CW-1:0];
    p4_clip_r <= |q0[Q_W-1:CW];
    p4_qd_r   <= QD_W'(q0[CW-1:0]) * QD_W'(DIV);
    for (int i = 0; i < ttrc_pkg::COMP_N; i++) begin
      comp_r[i] <= comp_nxt[i];
    end
    red_r   <= red_nxt;
    green_r <= green_nxt;
    blue_r  <= blue_nxt;
  end

  assign out_chan.valid = out_vld_r;
  assign out_chan.red   = red_r;
  assign out_chan.green = green_r;
  assign out_chan.blue  = blue_r;

endmodule

FILE: hw/rtl/touch_to_rgb_color.sv
// ----------------------------------------------------------------------------
// touch_to_rgb_color: touch position to rgb color
// hue from x, value from y, saturation from a register
// ----------------------------------------------------------------------------
// in_chan takes one touch sample per beat (touch_valid, touch_x, touch_y).
// a sample with touch_valid low, or at the last stored position, is taken
// and gives no result; any other sample is stored and gives one beat on
// out_chan with red, green and blue bytes.
// cfg_we/cfg_wdata write the saturation register (255 after reset); write
// it only while no sample is in flight. zero saturation gives gray.
// a result beat follows its input beat through the queue, the back end and
// its output register. the back end issues the four components in turn (v,
// p, q, t), then runs each through the four-stage scale, reciprocal multiply
// and correction pipeline and the output register; it takes the next sample
// only when it is done with the previous one.
// a two-entry job queue sits between the filter and the arithmetic, so the
// input keeps taking beats while a result waits; when the receiver stalls
// the result holds, the queue fills and in_chan.ready drops.
// reset clears the stored position to (0,0), the queue and the output.
// ----------------------------------------------------------------------------
module touch_to_rgb_color #(
  parameter int TOUCH_HEIGHT = 240
) (
  input  logic                     clk,
  input  logic                     rst_n,
  ttrc_in_if.sink                  in_chan,
  ttrc_out_if.source               out_chan,
  input  logic                     cfg_we,
  input  logic [ttrc_pkg::C_W-1:0] cfg_wdata
);

  logic [ttrc_pkg::C_W-1:0] sat_r, sat_nxt;
  logic                     push;
  logic                     pop;
  ttrc_pkg::job_t           push_job;
  ttrc_pkg::job_t           head_job;
  ttrc_pkg::qstat_t         q_stat;

  assign sat_nxt = cfg_we ? cfg_wdata : sat_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sat_r <= ttrc_pkg::C_MAX;
    end else begin
      sat_r <= sat_nxt;
    end
  end

  ttrc_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .q_stat   (q_stat),
    .push     (push),
    .push_job (push_job)
  );

  ttrc_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .head_job (head_job),
    .stat     (q_stat)
  );

  ttrc_back #(
    .TOUCH_HEIGHT (TOUCH_HEIGHT)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_stat   (q_stat),
    .head_job (head_job),
    .pop      (pop),
    .sat      (sat_r),
    .out_chan (out_chan)
  );

  a_push_has_room: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> q_stat.ready)
    else $error("job pushed into a full queue");

  a_no_job_for_idle_touch: assert property (@(posedge clk) disable iff (!rst_n)
    (in_chan.valid && in_chan.ready && !in_chan.touch_valid) |-> !push)
    else $error("idle touch sample produced a job");

  a_one_job_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    pop |=> !pop)
    else $error("back end took two jobs in a row");

  a_pop_needs_job: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> q_stat.valid)
    else $error("back end popped an empty queue");

endmodule

FILE: dv/touch_to_rgb_color_check.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// touch_to_rgb_color_check: color predictor and result checker
// watches the sample and color channels and the saturation write port,
// predicts each color from the stored position and saturation, and compares
// every result beat field by field with the oldest color still due
// ----------------------------------------------------------------------------
module touch_to_rgb_color_check #(
  parameter int TOUCH_HEIGHT = 240
) (
  input  logic                     clk,
  input  logic                     rst_n,
  ttrc_in_if                       in_mon,
  ttrc_out_if                      out_mon,
  input  logic                     cfg_we,
  input  logic [ttrc_pkg::C_W-1:0] cfg_wdata,
  output int                       colors_due,
  output int                       fail_count
);

  typedef struct packed {
    logic [ttrc_pkg::C_W-1:0] red;
    logic [ttrc_pkg::C_W-1:0] green;
    logic [ttrc_pkg::C_W-1:0] blue;
  } rgb_t;

  rgb_t                     rgb_due[$];
  rgb_t                     want;
  logic [ttrc_pkg::C_W-1:0] sat_reg;
  logic [ttrc_pkg::X_W-1:0] seen_x;
  logic [ttrc_pkg::Y_W-1:0] seen_y;
  int                       fails;

  initial begin
    fails = 0;
  end

  function automatic int clip(int v);
    return (v > int'(ttrc_pkg::C_MAX)) ? int'(ttrc_pkg::C_MAX) : v;
  endfunction

  function automatic rgb_t hsv_color(logic [ttrc_pkg::X_W-1:0] x,
                                     logic [ttrc_pkg::Y_W-1:0] y,
                                     logic [ttrc_pkg::C_W-1:0] s);
    int         h3, fr, sv, yv, cv, cp, cq, ct;
    int         cmax, full, span;
    logic [3:0] sector;
    rgb_t       c;
    cmax = int'(ttrc_pkg::C_MAX);
    full = int'(ttrc_pkg::FULL_TERM);
    span = ttrc_pkg::SECTOR_SPAN_I;
    sv   = int'(s);
    yv   = int'(y);
    cv   = clip(cmax * yv / TOUCH_HEIGHT);
    if (s == 0) begin
      c = {cv[ttrc_pkg::C_W-1:0], cv[ttrc_pkg::C_W-1:0], cv[ttrc_pkg::C_W-1:0]};
      return c;
    end
    // full turn folds back to red, beyond it stays in the last sector
    h3     = (x == ttrc_pkg::HUE_WRAP_X) ? 0 : 3 * int'(x);
    sector = 4'(h3 / span);
    fr     = h3 % span;
    cp = clip(yv * (cmax - sv) / TOUCH_HEIGHT);
    cq = clip(yv * (full - sv * fr) / (span * TOUCH_HEIGHT));
    ct = clip(yv * (full - sv * (span - fr)) / (span * TOUCH_HEIGHT));
    case (sector)
      ttrc_pkg::SEC_RY: c = {cv[ttrc_pkg::C_W-1:0], ct[ttrc_pkg::C_W-1:0],
                             cp[ttrc_pkg::C_W-1:0]};
      ttrc_pkg::SEC_YG: c = {cq[ttrc_pkg::C_W-1:0], cv[ttrc_pkg::C_W-1:0],
                             cp[ttrc_pkg::C_W-1:0]};
      ttrc_pkg::SEC_GC: c = {cp[ttrc_pkg::C_W-1:0], cv[ttrc_pkg::C_W-1:0],
                             ct[ttrc_pkg::C_W-1:0]};
      ttrc_pkg::SEC_CB: c = {cp[ttrc_pkg::C_W-1:0], cq[ttrc_pkg::C_W-1:0],
                             cv[ttrc_pkg::C_W-1:0]};
      ttrc_pkg::SEC_BM: c = {ct[ttrc_pkg::C_W-1:0], cp[ttrc_pkg::C_W-1:0],
                             cv[ttrc_pkg::C_W-1:0]};
      default:          c = {cv[ttrc_pkg::C_W-1:0], cp[ttrc_pkg::C_W-1:0],
                             cq[ttrc_pkg::C_W-1:0]};
    endcase
    return c;
  endfunction

  task automatic check_field(string name, logic [ttrc_pkg::C_W-1:0] exp_v,
                             logic [ttrc_pkg::C_W-1:0] got);
    if (exp_v !== got) begin
      $error("%s: expected %0d, actual %0d", name, exp_v, got);
      fails++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      sat_reg = ttrc_pkg::C_MAX;
      seen_x  = '0;
      seen_y  = '0;
      rgb_due.delete();
    end else begin
      if (out_mon.valid && out_mon.ready) begin
        if (rgb_due.size() == 0) begin
          $error("color beat with nothing due: red %0d green %0d blue %0d",
                 out_mon.red, out_mon.green, out_mon.blue);
          fails++;
        end else begin
          want = rgb_due.pop_front();
          check_field("red", want.red, out_mon.red);
          check_field("green", want.green, out_mon.green);
          check_field("blue", want.blue, out_mon.blue);
        end
      end
      // invalid samples and repeats of the stored position give no color
      if (in_mon.valid && in_mon.ready && in_mon.touch_valid &&
          !(in_mon.touch_x == seen_x && in_mon.touch_y == seen_y)) begin
        seen_x = in_mon.touch_x;
        seen_y = in_mon.touch_y;
        rgb_due.push_back(hsv_color(in_mon.touch_x, in_mon.touch_y, sat_reg));
      end
      if (cfg_we) begin
        sat_reg = cfg_wdata;
      end
    end
    colors_due <= rgb_due.size();
    fail_count <= fails;
  end

endmodule

FILE: dv/touch_to_rgb_color_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// touch_to_rgb_color_test: testbench top for the touch to rgb color block
// drives directed corner samples, then rounds of random samples under
// several saturation settings with random gaps on both channels; the
// checker beside the block predicts and compares every color
// ----------------------------------------------------------------------------
module touch_to_rgb_color_test;

  localparam int TOUCH_H     = 240;
  localparam int ROUND_ITEMS = 58;
  localparam int ROUNDS      = 7;
  localparam int SETTLE      = 24;

  logic                     clk;
  logic                     rst_n;
  logic                     cfg_we;
  logic [ttrc_pkg::C_W-1:0] cfg_wdata;
  int                       colors_due;
  int                       fail_count;
  bit                       tx_calm;
  bit                       rx_calm;
  int                       rx_gap;
  int                       fresh_items;
  logic [ttrc_pkg::X_W-1:0] sent_x;
  logic [ttrc_pkg::Y_W-1:0] sent_y;
  logic [ttrc_pkg::C_W-1:0] sat_plan [ROUNDS];

  ttrc_in_if  in_chan ();
  ttrc_out_if out_chan ();

  touch_to_rgb_color #(.TOUCH_HEIGHT(TOUCH_H)) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_chan   (in_chan),
    .out_chan  (out_chan),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  touch_to_rgb_color_check #(.TOUCH_HEIGHT(TOUCH_H)) color_check (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_mon     (in_chan),
    .out_mon    (out_chan),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .colors_due (colors_due),
    .fail_count (fail_count)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #3_000_000;
    $display("== FAIL ==");
    $finish;
  end

  function automatic int gap_len(bit calm);
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 88) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // color receiver
  initial begin
    out_chan.ready = 1'b0;
    forever begin
      repeat ($urandom_range(1, 24)) @(posedge clk);
      rx_gap = gap_len(rx_calm);
      if (rx_gap > 0) begin
        out_chan.ready <= 1'b0;
        repeat (rx_gap) @(posedge clk);
      end
      out_chan.ready <= 1'b1;
    end
  end

  task automatic send_sample(bit tv, logic [ttrc_pkg::X_W-1:0] x,
                             logic [ttrc_pkg::Y_W-1:0] y);
    int gap;
    in_chan.valid       <= 1'b1;
    in_chan.touch_valid <= tv;
    in_chan.touch_x     <= x;
    in_chan.touch_y     <= y;
    @(posedge clk);
    while (!in_chan.ready) @(posedge clk);
    if (tv && !(x == sent_x && y == sent_y)) begin
      sent_x = x;
      sent_y = y;
      fresh_items++;
    end
    gap = gap_len(tx_calm);
    if (gap > 0) begin
      in_chan.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // hold the sender until every color due has arrived
  task automatic drain();
    in_chan.valid <= 1'b0;
    @(posedge clk);
    while (colors_due != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_sat(logic [ttrc_pkg::C_W-1:0] v);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic random_round(logic [ttrc_pkg::C_W-1:0] sat, int target);
    int                       kind;
    int                       start;
    bit                       tv;
    logic [ttrc_pkg::X_W-1:0] x;
    logic [ttrc_pkg::Y_W-1:0] y;
    drain();
    write_sat(sat);
    tx_calm = ($urandom_range(0, 3) == 0);
    rx_calm = ($urandom_range(0, 3) == 0);
    start   = fresh_items;
    while (fresh_items - start < target) begin
      kind = $urandom_range(0, 99);
      tv   = 1'b1;
      x    = ttrc_pkg::X_W'($urandom_range(0, 319));
      y    = ttrc_pkg::Y_W'($urandom_range(0, 239));
      if (kind < 8) begin
        tv = 1'b0;
        x  = ttrc_pkg::X_W'($urandom_range(0, 511));
        y  = ttrc_pkg::Y_W'($urandom_range(0, 255));
      end else if (kind < 16) begin
        x = sent_x;
        y = sent_y;
      end else if (kind < 28) begin
        x = ttrc_pkg::X_W'($urandom_range(0, 511));
        y = ttrc_pkg::Y_W'($urandom_range(0, 255));
      end else if (kind < 34) begin
        case ($urandom_range(0, 3))
          0:       x = '0;
          1:       x = 9'd319;
          2:       x = ttrc_pkg::HUE_WRAP_X;
          default: x = '1;
        endcase
        y = ($urandom_range(0, 1) == 0) ? 8'd0 : 8'd255;
      end
      if ($urandom_range(0, 149) == 0) drain();
      send_sample(tv, x, y);
    end
  endtask

  initial begin
    rst_n               = 1'b0;
    cfg_we              = 1'b0;
    cfg_wdata           = '0;
    in_chan.valid       = 1'b0;
    in_chan.touch_valid = 1'b0;
    in_chan.touch_x     = '0;
    in_chan.touch_y     = '0;
    sent_x              = '0;
    sent_y              = '0;
    fresh_items         = 0;
    tx_calm             = 1'b0;
    rx_calm             = 1'b0;
    sat_plan = '{8'd128, 8'd1, ttrc_pkg::C_MAX, 8'd0, 8'd254,
                 8'($urandom_range(2, 253)), 8'($urandom_range(2, 253))};
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // reset saturation
    send_sample(1'b1, 9'd0, 8'd0);
    send_sample(1'b0, 9'd319, 8'd239);
    send_sample(1'b1, 9'd319, 8'd239);
    send_sample(1'b1, 9'd319, 8'd239);
    send_sample(1'b1, ttrc_pkg::HUE_WRAP_X, 8'd120);
    send_sample(1'b1, 9'd511, 8'd255);
    send_sample(1'b1, 9'd0, 8'd240);
    send_sample(1'b1, 9'd10, 8'd200);
    send_sample(1'b1, 9'd60, 8'd200);
    send_sample(1'b1, 9'd110, 8'd200);
    send_sample(1'b1, 9'd170, 8'd200);
    send_sample(1'b1, 9'd220, 8'd200);
    send_sample(1'b1, 9'd270, 8'd200);
    send_sample(1'b1, 9'd330, 8'd200);
    send_sample(1'b1, 9'd480, 8'd200);
    send_sample(1'b1, 9'd53, 8'd239);
    send_sample(1'b1, 9'd0, 8'd255);
    send_sample(1'b0, 9'd0, 8'd0);

    // gray
    drain();
    write_sat(8'd0);
    send_sample(1'b1, 9'd100, 8'd150);
    send_sample(1'b1, 9'd300, 8'd239);
    send_sample(1'b1, 9'd0, 8'd0);
    send_sample(1'b1, 9'd511, 8'd255);

    drain();
    write_sat(8'd1);
    send_sample(1'b1, 9'd200, 8'd100);
    send_sample(1'b1, ttrc_pkg::HUE_WRAP_X, 8'd255);

    for (int i = 0; i < ROUNDS; i++) begin
      random_round(sat_plan[i], ROUND_ITEMS);
    end

    tx_calm = 1'b0;
    rx_calm = 1'b0;
    drain();
    if (fail_count == 0 && colors_due == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

FILE: filelist.f
hw/rtl/ttrc_pkg.sv
hw/rtl/ttrc_in_if.sv
hw/rtl/ttrc_out_if.sv
hw/rtl/ttrc_queue.sv
hw/rtl/ttrc_front.sv
hw/rtl/ttrc_back.sv
hw/rtl/touch_to_rgb_color.sv
dv/touch_to_rgb_color_check.sv
dv/touch_to_rgb_color_test.sv
